@@ hdl/draw_without_replacement_shuffler_macros.svh @@
// assertion helpers for the shuffler rtl
`ifndef DRAW_WITHOUT_REPLACEMENT_SHUFFLER_MACROS_SVH
`define DRAW_WITHOUT_REPLACEMENT_SHUFFLER_MACROS_SVH

// checked at every rising clock edge outside reset
`define DWRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every rising clock edge, reset included
`define DWRS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/dwrs_pkg.sv @@
`timescale 1ns / 1ps

package dwrs_pkg;

  // field widths
  localparam int VALUE_W = 10;
  localparam int RAND_W  = 64;
  localparam int SIZE_W  = 11;

  // command codes
  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_DRAW    = 1'b1;

  // reset value of the pool size register
  localparam logic [SIZE_W-1:0] POOL_SIZE_RST = SIZE_W'(1024);

  typedef struct packed {
    logic              command;
    logic [RAND_W-1:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] drawn_value;
    logic               last_draw;
    logic               pool_empty;
  } out_item_t;

endpackage

@@ hdl/dwrs_ram.sv @@
`timescale 1ns / 1ps

module dwrs_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/dwrs_mod.sv @@
`timescale 1ns / 1ps

module dwrs_mod #(
  parameter int DIV_W = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dwrs_pkg::RAND_W-1:0] dividend,
  input  logic [DIV_W-1:0]            divisor,
  output logic                        done,
  output logic [DIV_W-1:0]            remainder
);

  import dwrs_pkg::*;

  localparam int CNT_W = $clog2(RAND_W);

  logic [RAND_W-1:0] shreg;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIV_W:0]    trial;
  logic [DIV_W-1:0]  rem_next;

  // restoring step: bring in one dividend bit, subtract when it fits
  always_comb begin
    trial = {remainder, shreg[RAND_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = DIV_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = DIV_W'(trial);
    end
  end

  // one dividend bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy      <= 1'b1;
        done      <= 1'b0;
        cnt       <= '0;
        shreg     <= dividend;
        remainder <= '0;
      end else if (busy) begin
        shreg     <= {shreg[RAND_W-2:0], 1'b0};
        remainder <= rem_next;
        cnt       <= cnt + 1'b1;
        if (cnt == CNT_W'(RAND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/draw_without_replacement_shuffler.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | in_data (command, random_value)
// out     | output    | out_valid / out_ready  | out_data (drawn_value, last_draw, pool_empty)
// cfg     | input     | cfg_wr_en              | cfg_wr_data (pool_size)
// a draw runs the bit-serial modulo over all 64 random bits, reads the drawn slot and the
// last entry, moves the last entry into the slot, loads the output register, then idles
// a restart writes min(pool_size, POOL_DEPTH) store entries, one store entry per cycle
// a refused draw goes from idle straight to the output register; one item is in work at a time
// rst is synchronous; after reset the pool is empty and pool_size is 1024
// a stalled result holds in the output register; the next item runs, then waits for it

`include "draw_without_replacement_shuffler_macros.svh"

module draw_without_replacement_shuffler #(
  parameter int POOL_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dwrs_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dwrs_pkg::out_item_t         out_data,
  input  logic                        cfg_wr_en,
  input  logic [dwrs_pkg::SIZE_W-1:0] cfg_wr_data
);

  import dwrs_pkg::*;

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_DIV,
    S_RD0,
    S_RD1,
    S_RD2,
    S_DONE
  } state_t;

  state_t            state;
  logic [SIZE_W-1:0] pool_size;
  logic [CW-1:0]     rc;
  logic [CW-1:0]     fill_idx;
  logic [CW-1:0]     fill_n;
  logic [AW-1:0]     slot;
  logic [AW-1:0]     last_slot;
  out_item_t         res;

  logic               in_xfer;
  logic               mod_start;
  logic               mod_done;
  logic [CW-1:0]      mod_rem;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign mod_start = in_xfer && (in_data.command == CMD_DRAW) && (rc != '0);
  assign last_slot = AW'(rc - 1'b1);

  // restart size, clipped to the store depth
  always_comb begin
    if (32'(pool_size) > 32'(POOL_DEPTH)) begin
      fill_n = CW'(POOL_DEPTH);
    end else begin
      fill_n = CW'(pool_size);
    end
  end

  // store port control: identity fill or swap-in of the last entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_idx[AW-1:0];
    ram_wdata = VALUE_W'(fill_idx);
    ram_raddr = slot;
    if (state == S_FILL) begin
      ram_we = 1'b1;
    end else if (state == S_RD2) begin
      ram_we    = 1'b1;
      ram_waddr = slot;
      ram_wdata = ram_rdata;
    end
    if (state == S_RD1) begin
      ram_raddr = last_slot;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= POOL_SIZE_RST;
    end else if (cfg_wr_en) begin
      pool_size <= cfg_wr_data;
    end
  end

  // control sequence and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_data.command == CMD_RESTART) begin
              res      <= '0;
              rc       <= fill_n;
              fill_idx <= '0;
              state    <= (fill_n == '0) ? S_DONE : S_FILL;
            end else if (rc == '0) begin
              res   <= '{drawn_value: '0, last_draw: 1'b0, pool_empty: 1'b1};
              state <= S_DONE;
            end else begin
              res   <= '0;
              state <= S_DIV;
            end
          end
        end
        S_FILL: begin
          fill_idx <= fill_idx + 1'b1;
          if (fill_idx == rc - 1'b1) begin
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (mod_done) begin
            slot  <= mod_rem[AW-1:0];
            state <= S_RD0;
          end
        end
        S_RD0: begin
          state <= S_RD1;
        end
        S_RD1: begin
          res.drawn_value <= ram_rdata;
          state           <= S_RD2;
        end
        S_RD2: begin
          rc            <= rc - 1'b1;
          res.last_draw <= (rc == CW'(1));
          state         <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  dwrs_mod #(
    .DIV_W(CW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (in_data.random_value),
    .divisor  (rc),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  dwrs_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(POOL_DEPTH)
  ) u_pool (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // checks
  `DWRS_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !out_valid), "not idle after reset")
  `DWRS_ASSERT(a_rc_range, 32'(rc) <= 32'(POOL_DEPTH), "remaining count above depth")
  `DWRS_ASSERT(a_mod_done_in_div, mod_done |-> (state == S_DIV), "modulo done outside draw")
  `DWRS_ASSERT(a_slot_live, (state == S_RD0) |-> (32'(slot) < 32'(rc)), "drawn slot not live")
  `DWRS_ASSERT(a_refused,
    (in_xfer && in_data.command == CMD_DRAW && rc == '0) |=>
      (state == S_DONE && res.pool_empty), "empty draw not refused")

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import dwrs_pkg::*;

  localparam int POOL_DEPTH  = 1024;
  localparam int ITEM_GOAL   = 550;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 80;

  // one row of the directed sequence; res is used when fixed is set
  typedef struct packed {
    logic              set_size;
    logic [SIZE_W-1:0] size;
    logic              command;
    logic [RAND_W-1:0] rnd;
    logic              fixed;
    out_item_t         res;
  } plan_row_t;

  localparam int NUM_ROWS = 24;
  localparam plan_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
    // draw right after reset, pool is empty
    '{1'b0, 11'd0,    CMD_DRAW,    64'd0,                  1'b1, '{10'd0, 1'b0, 1'b1}},
    // restart with the reset pool size
    '{1'b0, 11'd0,    CMD_RESTART, 64'd0,                  1'b1, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0,    CMD_DRAW,    64'd0,                  1'b1, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0,    CMD_DRAW,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{1'b0, 11'd0,    CMD_DRAW,    64'd1021,               1'b0, '0},
    // single entry pool: first draw is the last one
    '{1'b1, 11'd1,    CMD_RESTART, 64'd0,                  1'b1, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0,    CMD_DRAW,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{10'd0, 1'b1, 1'b0}},
    '{1'b0, 11'd0,    CMD_DRAW,    64'd7,                  1'b1, '{10'd0, 1'b0, 1'b1}},
    // pool size zero leaves the pool empty
    '{1'b1, 11'd0,    CMD_RESTART, 64'd0,                  1'b1, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0,    CMD_DRAW,    64'd3,                  1'b1, '{10'd0, 1'b0, 1'b1}},
    // oversized pool saturates to the store depth
    '{1'b1, 11'd2047, CMD_RESTART, 64'd0,                  1'b1, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0,    CMD_DRAW,    64'h8000_0000_0000_0000, 1'b0, '0},
    '{1'b0, 11'd0,    CMD_DRAW,    64'd1023,               1'b0, '0},
    '{1'b1, 11'd1025, CMD_RESTART, 64'd0,                  1'b1, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0,    CMD_DRAW,    64'd1024,               1'b1, '{10'd0, 1'b0, 1'b0}},
    // last entry moved into slot zero by the draw above
    '{1'b0, 11'd0,    CMD_DRAW,    64'd1023,               1'b1, '{10'd1023, 1'b0, 1'b0}},
    // two entry pool drawn to empty, then refused
    '{1'b1, 11'd2,    CMD_RESTART, 64'd0,                  1'b1, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0,    CMD_DRAW,    64'd1,                  1'b1, '{10'd1, 1'b0, 1'b0}},
    '{1'b0, 11'd0,    CMD_DRAW,    64'd5,                  1'b1, '{10'd0, 1'b1, 1'b0}},
    '{1'b0, 11'd0,    CMD_DRAW,    64'd0,                  1'b1, '{10'd0, 1'b0, 1'b1}},
    // restart without a new size
    '{1'b0, 11'd0,    CMD_RESTART, 64'd0,                  1'b1, '{10'd0, 1'b0, 1'b0}},
    '{1'b0, 11'd0,    CMD_DRAW,    64'h5555_5555_5555_5555, 1'b0, '0},
    '{1'b0, 11'd0,    CMD_DRAW,    64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
    '{1'b1, 11'd1024, CMD_RESTART, 64'd0,                  1'b1, '{10'd0, 1'b0, 1'b0}}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0]   cfg_wr_data = '0;

  // mirror of the shuffler state
  logic [VALUE_W-1:0]  pool_mirror [0:POOL_DEPTH-1];
  logic [SIZE_W-1:0]   live_count;
  logic [SIZE_W-1:0]   pool_size_mirror;

  out_item_t           picks_due [$];
  int                  mismatch_cnt = 0;
  int                  results_seen = 0;
  int                  items_sent = 0;
  int                  cycle_cnt = 0;
  bit                  keep_feeding = 1'b0;

  draw_without_replacement_shuffler #(
    .POOL_DEPTH(POOL_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // expected result of one item; updates the mirrored pool
  function automatic out_item_t predict_pick(input in_item_t it);
    out_item_t          res;
    logic [RAND_W-1:0]  slot;
    logic [SIZE_W-1:0]  fill;
    res = '0;
    if (it.command == CMD_RESTART) begin
      fill = (pool_size_mirror > SIZE_W'(POOL_DEPTH)) ? SIZE_W'(POOL_DEPTH) : pool_size_mirror;
      for (int i = 0; i < int'(fill); i++) begin
        pool_mirror[i] = VALUE_W'(i);
      end
      live_count = fill;
    end else if (live_count == '0 || live_count > SIZE_W'(POOL_DEPTH)) begin
      res.pool_empty = 1'b1;
    end else begin
      slot = it.random_value % RAND_W'(live_count);
      res.drawn_value = pool_mirror[slot];
      pool_mirror[slot] = pool_mirror[live_count - 1'b1];
      live_count = live_count - 1'b1;
      res.last_draw = (live_count == '0);
    end
    return res;
  endfunction

  // offer one item, wait for its transfer and log what it should produce
  task automatic send_item(input in_item_t it, input bit fixed, input out_item_t res);
    int        gap;
    int        roll;
    out_item_t calc;
    gap = 0;
    if (!keep_feeding) begin
      roll = $urandom_range(0, 99);
      if (roll >= 94) gap = $urandom_range(20, 90);
      else if (roll >= 60) gap = $urandom_range(1, 4);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    calc = predict_pick(it);
    picks_due.push_back(fixed ? res : calc);
    items_sent++;
  endtask

  // drain the block, then write the pool size register
  task automatic write_pool_size(input logic [SIZE_W-1:0] size);
    @(negedge clk);
    in_valid <= 1'b0;
    while (picks_due.size() != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    pool_size_mirror = size;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (picks_due.size() == 0) begin
        $display("%0t: result expected none, actual %p", $time, out_data);
        mismatch_cnt++;
      end else begin
        want = picks_due.pop_front();
        if (out_data.drawn_value !== want.drawn_value) begin
          $display("%0t: drawn_value expected %0d actual %0d", $time,
                   want.drawn_value, out_data.drawn_value);
          mismatch_cnt++;
        end
        if (out_data.last_draw !== want.last_draw) begin
          $display("%0t: last_draw expected %0b actual %0b", $time,
                   want.last_draw, out_data.last_draw);
          mismatch_cnt++;
        end
        if (out_data.pool_empty !== want.pool_empty) begin
          $display("%0t: pool_empty expected %0b actual %0b", $time,
                   want.pool_empty, out_data.pool_empty);
          mismatch_cnt++;
        end
      end
    end
  end

  // receiver: bursts with and without stalls, a few long stalls, one long hold-off
  initial begin
    int  burst;
    int  stall_pct;
    bit  held;
    held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      burst     = $urandom_range(10, 150);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
      repeat (burst) begin
        @(negedge clk);
        if (!held && results_seen >= 60 && in_valid) begin
          // block fills up while the sender keeps offering
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end else if (stall_pct != 0 && $urandom_range(0, 199) == 0) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(20, 60)) @(negedge clk);
        end
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // reset, directed rows, random phases, end of run
  initial begin
    in_item_t          it;
    logic [SIZE_W-1:0] size;
    int                n_draws;

    foreach (pool_mirror[i]) pool_mirror[i] = '0;
    live_count       = '0;
    pool_size_mirror = POOL_SIZE_RST;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed sequence
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED_ROWS[r].set_size) write_pool_size(DIRECTED_ROWS[r].size);
      it.command      = DIRECTED_ROWS[r].command;
      it.random_value = DIRECTED_ROWS[r].rnd;
      send_item(it, DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].res);
    end

    // random phases: mostly full shuffles of small pools
    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 19))
        0:       size = '0;
        1:       size = SIZE_W'($urandom_range(1025, 2047));
        2:       size = SIZE_W'($urandom_range(65, 1024));
        default: size = SIZE_W'($urandom_range(1, 64));
      endcase
      if ($urandom_range(0, 3) != 0) write_pool_size(size);
      keep_feeding = ($urandom_range(0, 3) == 0);

      if ($urandom_range(0, 5) != 0) begin
        it.command      = CMD_RESTART;
        it.random_value = {$urandom, $urandom};
        send_item(it, 1'b0, '0);
        n_draws = (live_count > 48) ? $urandom_range(1, 40)
                                    : int'(live_count) + $urandom_range(0, 2);
        repeat (n_draws) begin
          it.command = CMD_DRAW;
          case ($urandom_range(0, 9))
            0:       it.random_value = '1;
            1:       it.random_value = '0;
            2:       it.random_value = RAND_W'($urandom_range(0, 2047));
            3:       it.random_value = RAND_W'(live_count) - 1'b1;
            default: it.random_value = {$urandom, $urandom};
          endcase
          send_item(it, 1'b0, '0);
        end
      end else begin
        // noise: random commands
        repeat ($urandom_range(1, 8)) begin
          it.command      = ($urandom_range(0, 3) == 0) ? CMD_RESTART : CMD_DRAW;
          it.random_value = {$urandom, $urandom};
          send_item(it, 1'b0, '0);
        end
      end
    end

    // drain and finish
    @(negedge clk);
    in_valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
